>>> src/orpc_pkg.sv
// shared types and constants for the onc rpc record deframer and validator
package orpc_pkg;

  // field offset counter, wide enough to hold a full header capture
  localparam int unsigned FLD_W = 7;

  localparam logic [31:0] ANY_XID    = 32'hFFFF_FFFF;
  localparam logic [31:0] PROG_LIMIT = 32'h6000_0000;
  localparam logic [31:0] PORTMAP    = 32'd100000;

  localparam logic [1:0] V_OK = 2'd0;
  localparam logic [1:0] V_NC = 2'd1;
  localparam logic [1:0] V_NM = 2'd2;

  typedef enum logic [7:0] {
    PH_MARK   = 8'b0000_0001,
    PH_HEAD   = 8'b0000_0010,
    PH_CRED   = 8'b0000_0100,
    PH_CBODY  = 8'b0000_1000,
    PH_VERF   = 8'b0001_0000,
    PH_VBODY  = 8'b0010_0000,
    PH_STATUS = 8'b0100_0000,
    PH_TAIL   = 8'b1000_0000
  } ph_e;

  typedef enum logic [2:0] {
    EX_CALL  = 3'b001,
    EX_REPLY = 3'b010,
    EX_DONE  = 3'b100
  } ex_e;

  typedef enum logic [1:0] {
    PM_NONE    = 2'd0,
    PM_GETADDR = 2'd1,
    PM_GETPORT = 2'd2
  } pm_e;

  typedef enum logic [1:0] {
    EV_REC  = 2'd0,
    EV_BAIL = 2'd1,
    EV_NM   = 2'd2
  } ev_kind_e;

  // one request from the parser to the exchange checker
  typedef struct packed {
    ev_kind_e    kind;
    logic        dir;
    logic [31:0] xid;
    logic [31:0] prog;
    logic        c_basic;
    logic        c_v3p3;
    logic        c_v2p3;
    logic        c_ga;
    logic        c_gp;
    logic        r_basic;
    logic        r_rs0;
    logic        r_rs1;
    logic        r_st4;
    logic        r_st5;
    logic        r_ga;
    logic        r_gp;
  } ev_t;

endpackage

>>> src/orpc_front.sv
// per-direction record marking parser that classifies completed records and reports failed ones
module orpc_front import orpc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 56
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       from_responder_i,
  output logic       ev_valid_o,
  output ev_t        ev_o,
  input  logic       ev_ready_i
);

  localparam int unsigned AW = $clog2(HEADER_BYTES);
  localparam logic [FLD_W-1:0] HB = FLD_W'(HEADER_BYTES);

  // current byte
  logic       cur_v_q;
  logic [7:0] cur_b_q;
  logic       cur_d_q;
  logic [2:0] iter_q;
  logic       halted_q;

  // per-direction parser state
  ph_e              ph_q  [2];
  ph_e              rph_q [2];
  logic [31:0]      fw_q  [2];
  logic [31:0]      fo_q  [2];
  logic [31:0]      abl_q [2];
  logic [FLD_W-1:0] fld_q [2];
  logic [1:0]       mc_q  [2];

  logic [7:0] hdr_q [2][HEADER_BYTES];

  ph_e              s_ph, s_rph, n_ph, n_rph;
  logic [31:0]      s_fw, s_fo, s_abl, n_fw, n_fo, n_abl;
  logic [FLD_W-1:0] s_fld, n_fld, cls_size;
  logic [1:0]       s_mc, n_mc;
  logic [30:0]      flen;
  logic             fs, fs2, do_vb;
  logic             cons, bail, emit, close, done, step_en;
  logic             wr_hit;
  logic [FLD_W-1:0] wr_addr, head_base, verf_base;
  logic [31:0]      a;
  logic [7:0]       view [64];
  logic [31:0]      w0, w1, w2, w3, w4, w5, w6, w7, w9, w12;

  assign s_ph  = ph_q[cur_d_q];
  assign s_rph = rph_q[cur_d_q];
  assign s_fw  = fw_q[cur_d_q];
  assign s_fo  = fo_q[cur_d_q];
  assign s_abl = abl_q[cur_d_q];
  assign s_fld = fld_q[cur_d_q];
  assign s_mc  = mc_q[cur_d_q];

  assign flen      = s_fw[30:0];
  assign fs        = (s_fo != {1'b0, flen});
  assign head_base = cur_d_q ? FLD_W'(12) : FLD_W'(24);
  assign verf_base = cur_d_q ? FLD_W'(12) : FLD_W'(32);

  // header store write for this step
  always_comb begin
    wr_hit  = 1'b0;
    wr_addr = '0;
    case (s_ph)
      PH_HEAD: begin
        wr_hit  = fs && (s_fld < head_base);
        wr_addr = s_fld;
      end
      PH_CRED: begin
        wr_hit  = fs && (s_fld < FLD_W'(8));
        wr_addr = FLD_W'(24) + s_fld;
      end
      PH_VERF: begin
        wr_hit  = fs && (s_fld < FLD_W'(8));
        wr_addr = verf_base + s_fld;
      end
      PH_STATUS: begin
        wr_hit  = fs && (s_fld < FLD_W'(4));
        wr_addr = FLD_W'(20) + s_fld;
      end
      PH_TAIL: begin
        wr_hit  = fs && (s_fld < HB);
        wr_addr = s_fld;
      end
      default: ;
    endcase
  end

  // store view with the byte of this step merged in, zero past the store
  for (genvar j = 0; j < 64; j++) begin : g_view
    if (j < HEADER_BYTES) begin : g_in
      assign view[j] = (wr_hit && wr_addr == FLD_W'(j)) ? cur_b_q : hdr_q[cur_d_q][j];
    end else begin : g_out
      assign view[j] = 8'h00;
    end
  end

  assign w0  = {view[0],  view[1],  view[2],  view[3]};
  assign w1  = {view[4],  view[5],  view[6],  view[7]};
  assign w2  = {view[8],  view[9],  view[10], view[11]};
  assign w3  = {view[12], view[13], view[14], view[15]};
  assign w4  = {view[16], view[17], view[18], view[19]};
  assign w5  = {view[20], view[21], view[22], view[23]};
  assign w6  = {view[24], view[25], view[26], view[27]};
  assign w7  = {view[28], view[29], view[30], view[31]};
  assign w9  = {view[36], view[37], view[38], view[39]};
  assign w12 = {view[48], view[49], view[50], view[51]};

  // one parser step
  always_comb begin
    n_ph     = s_ph;
    n_rph    = s_rph;
    n_fw     = s_fw;
    n_fo     = s_fo;
    n_abl    = s_abl;
    n_fld    = s_fld;
    n_mc     = s_mc;
    cons     = 1'b0;
    bail     = 1'b0;
    emit     = 1'b0;
    close    = 1'b0;
    do_vb    = 1'b0;
    fs2      = 1'b0;
    a        = '0;
    cls_size = s_fld;
    case (s_ph)
      PH_MARK: begin
        n_fw = {s_fw[23:0], cur_b_q};
        cons = 1'b1;
        if (s_mc == 2'd3) begin
          n_mc = '0;
          n_fo = '0;
          n_ph = s_rph;
        end else begin
          n_mc = s_mc + 2'd1;
        end
      end
      PH_HEAD: begin
        if (wr_hit) begin
          n_fld = s_fld + FLD_W'(1);
          n_fo  = s_fo + 32'd1;
          cons  = 1'b1;
        end
        if (n_fld >= head_base) begin
          if (!cur_d_q) begin
            if (w1 != 32'd0 || w2 != 32'd2) begin
              bail = 1'b1;
            end else begin
              n_ph  = PH_CRED;
              n_fld = '0;
            end
          end else if (w1 != 32'd1) begin
            emit = 1'b1;
          end else begin
            n_ph  = PH_VERF;
            n_fld = '0;
          end
        end
      end
      PH_CRED: begin
        if (wr_hit) begin
          n_fld = s_fld + FLD_W'(1);
          n_fo  = s_fo + 32'd1;
          cons  = 1'b1;
        end
        if (n_fld >= FLD_W'(8)) begin
          a = w7;
          if (({1'b0, n_fo} + {1'b0, a}) > {2'b0, flen}) begin
            bail = 1'b1;
          end else begin
            n_abl = a;
            n_ph  = PH_CBODY;
            n_fld = '0;
          end
        end
      end
      PH_CBODY: begin
        if (fs && s_abl != 32'd0) begin
          n_abl = s_abl - 32'd1;
          n_fo  = s_fo + 32'd1;
          cons  = 1'b1;
        end
        if (n_abl == 32'd0) begin
          n_ph  = PH_VERF;
          n_fld = '0;
        end
      end
      PH_VERF: begin
        if (wr_hit) begin
          n_fld = s_fld + FLD_W'(1);
          n_fo  = s_fo + 32'd1;
          cons  = 1'b1;
        end
        if (n_fld >= FLD_W'(8)) begin
          a = cur_d_q ? w4 : w9;
          if (({1'b0, n_fo} + {1'b0, a}) > {2'b0, flen}) begin
            bail = 1'b1;
          end else begin
            n_abl = a;
            n_ph  = PH_VBODY;
            n_fld = '0;
            do_vb = 1'b1;
            fs2   = fs && !cons;
          end
        end
      end
      PH_VBODY: begin
        do_vb = 1'b1;
        fs2   = fs;
      end
      PH_STATUS: begin
        if (wr_hit) begin
          n_fld = s_fld + FLD_W'(1);
          n_fo  = s_fo + 32'd1;
          cons  = 1'b1;
        end
        if (n_fld >= FLD_W'(4)) begin
          n_ph  = PH_TAIL;
          n_fld = FLD_W'(24);
        end
        // fragment ends inside or right after the status word
        if (n_fo >= {1'b0, flen}) close = 1'b1;
      end
      PH_TAIL: begin
        if (fs) begin
          if (wr_hit) n_fld = s_fld + FLD_W'(1);
          n_fo = s_fo + 32'd1;
          cons = 1'b1;
        end
        if (n_fo >= {1'b0, flen}) close = 1'b1;
      end
      default: n_ph = PH_MARK;
    endcase

    // verifier body, also entered straight from the verifier length
    if (do_vb) begin
      if (fs2 && n_abl != 32'd0) begin
        n_abl = n_abl - 32'd1;
        n_fo  = n_fo + 32'd1;
        cons  = 1'b1;
      end
      if (n_abl == 32'd0) begin
        if (!cur_d_q) begin
          n_ph  = PH_TAIL;
          n_fld = FLD_W'(40);
          if (n_fo >= {1'b0, flen}) close = 1'b1;
        end else begin
          n_ph = PH_STATUS;
          if (({1'b0, n_fo} + 33'd4) > {2'b0, flen}) bail = 1'b1;
          n_fld = '0;
        end
      end
    end

    if (close) begin
      cls_size = n_fld;
      if (s_fw[31]) begin
        n_rph = PH_HEAD;
        n_fld = '0;
      end else begin
        n_rph = n_ph;
      end
      n_ph = PH_MARK;
    end

    // fragment ran out mid-header
    if (!bail && !emit && n_ph != PH_MARK && n_ph != PH_TAIL &&
        n_fo >= {1'b0, n_fw[30:0]}) begin
      if (n_fw[31]) begin
        bail = 1'b1;
      end else begin
        n_rph = n_ph;
        n_ph  = PH_MARK;
      end
    end
  end

  // record classification for the exchange checker
  always_comb begin
    ev_o = '0;
    ev_o.kind    = bail ? EV_BAIL : (emit ? EV_NM : EV_REC);
    ev_o.dir     = cur_d_q;
    ev_o.xid     = w0;
    ev_o.prog    = w3;
    ev_o.c_basic = (cls_size >= FLD_W'(40)) && (w1 == 32'd0) && (w2 == 32'd2);
    ev_o.c_v3p3  = (w4 == 32'd3) && (w5 == 32'd3);
    ev_o.c_v2p3  = (w4 == 32'd2) && (w5 == 32'd3);
    ev_o.c_ga    = (cls_size >= FLD_W'(52)) && (w12 != 32'd0) && (w12[31:7] == '0) &&
                   (w12[6:0] <= (cls_size - FLD_W'(52)));
    ev_o.c_gp    = (cls_size >= FLD_W'(56));
    ev_o.r_basic = (cls_size >= FLD_W'(24)) && (w1 == 32'd1);
    ev_o.r_rs0   = (w2 == 32'd0);
    ev_o.r_rs1   = (w2 == 32'd1);
    ev_o.r_st4   = (w5 > 32'd4);
    ev_o.r_st5   = (w5 > 32'd5);
    ev_o.r_ga    = (cls_size >= FLD_W'(28)) && (w6 != 32'd0) && (w6[31:7] == '0) &&
                   (w6[6:0] <= (cls_size - FLD_W'(28)));
    ev_o.r_gp    = (cls_size >= FLD_W'(28));
  end

  assign step_en    = cur_v_q && !halted_q && ev_ready_i;
  assign ev_valid_o = step_en && (bail || emit || (close && s_fw[31]));
  assign done       = cons || bail || emit || (iter_q == 3'd7);
  assign in_ready_o = !cur_v_q || halted_q || (step_en && done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q  <= 1'b0;
      iter_q   <= '0;
      halted_q <= 1'b0;
      for (int d = 0; d < 2; d++) begin
        ph_q[d]  <= PH_MARK;
        rph_q[d] <= PH_HEAD;
        fw_q[d]  <= '0;
        fo_q[d]  <= '0;
        abl_q[d] <= '0;
        fld_q[d] <= '0;
        mc_q[d]  <= '0;
      end
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur_v_q <= 1'b1;
        iter_q  <= '0;
      end else if (in_ready_o) begin
        cur_v_q <= 1'b0;
      end else if (step_en) begin
        iter_q <= iter_q + 3'd1;
      end
      if (step_en) begin
        if (bail) halted_q <= 1'b1;
        ph_q[cur_d_q]  <= n_ph;
        rph_q[cur_d_q] <= n_rph;
        fw_q[cur_d_q]  <= n_fw;
        fo_q[cur_d_q]  <= n_fo;
        abl_q[cur_d_q] <= n_abl;
        fld_q[cur_d_q] <= n_fld;
        mc_q[cur_d_q]  <= n_mc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_b_q <= data_byte_i;
      cur_d_q <= from_responder_i;
    end
    if (step_en && wr_hit) begin
      hdr_q[cur_d_q][wr_addr[AW-1:0]] <= cur_b_q;
    end
  end

endmodule

>>> src/orpc_evq.sv
// two-entry request queue between parser and exchange checker
module orpc_evq import orpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  ev_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ev_t  out_o
);

  ev_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_i;
  end

endmodule

>>> src/orpc_back.sv
// call/reply exchange checker and result register
module orpc_back import orpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ev_valid_i,
  output logic        ev_ready_o,
  input  ev_t         ev_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        verdict_direction_o,
  output logic [31:0] program_number_o
);

  ex_e         ex_q, ex_d;
  logic [31:0] sx_q, sx_d, sp_q, sp_d;
  pm_e         kind_q, kind_d;
  logic        out_v_q;
  logic [1:0]  verdict_q;
  logic        dir_q;
  logic [31:0] prog_q;

  logic        pop, has_v, xmatch;
  logic [1:0]  v;
  logic [31:0] p;

  assign ev_ready_o = !out_v_q || out_ready_i;
  assign pop        = ev_valid_i && ev_ready_o;
  assign xmatch     = (sx_q == ev_i.xid) || (sx_q == ANY_XID);

  always_comb begin
    ex_d   = ex_q;
    sx_d   = sx_q;
    sp_d   = sp_q;
    kind_d = kind_q;
    has_v  = 1'b0;
    v      = V_NM;
    p      = '0;
    case (ev_i.kind)
      EV_BAIL: begin
        has_v = 1'b1;
        v     = ev_i.dir ? V_NM : V_NC;
      end
      EV_NM: begin
        has_v = 1'b1;
      end
      EV_REC: begin
        case (ex_q)
          EX_CALL: begin
            if (!ev_i.dir) begin
              ex_d = EX_DONE;
              if (!ev_i.c_basic) begin
                has_v = 1'b1;
                v     = V_NC;
              end else begin
                sp_d = ev_i.prog;
                if (ev_i.prog >= PROG_LIMIT) begin
                  has_v = 1'b1;
                  v     = V_NC;
                end else begin
                  kind_d = PM_NONE;
                  if (ev_i.prog == PORTMAP && ev_i.c_v3p3) begin
                    if (!ev_i.c_ga) begin
                      has_v = 1'b1;
                      v     = V_NC;
                    end else begin
                      kind_d = PM_GETADDR;
                    end
                  end else if (ev_i.prog == PORTMAP && ev_i.c_v2p3) begin
                    if (!ev_i.c_gp) begin
                      has_v = 1'b1;
                      v     = V_NC;
                    end else begin
                      kind_d = PM_GETPORT;
                    end
                  end
                  if (!has_v) begin
                    sx_d = ev_i.xid;
                    ex_d = EX_REPLY;
                  end
                end
              end
            end
          end
          EX_REPLY: begin
            if (ev_i.dir) begin
              ex_d  = EX_DONE;
              has_v = 1'b1;
              if (ev_i.r_basic && xmatch) begin
                if (ev_i.r_rs0) begin
                  if (!ev_i.r_st4) begin
                    if (sx_q == ANY_XID && ev_i.xid != ANY_XID) begin
                      // wildcard call answered: back to waiting for a call
                      ex_d  = EX_CALL;
                      has_v = 1'b0;
                    end else if ((kind_q == PM_GETADDR && !ev_i.r_ga) ||
                                 (kind_q == PM_GETPORT && !ev_i.r_gp)) begin
                      v = V_NM;
                    end else begin
                      ex_d = EX_CALL;
                      v    = V_OK;
                      p    = sp_q;
                    end
                  end
                end else if (ev_i.r_rs1 && !ev_i.r_st5) begin
                  ex_d = EX_CALL;
                  v    = V_OK;
                end
              end
            end
          end
          default: has_v = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q    <= EX_CALL;
      sx_q    <= '0;
      sp_q    <= '0;
      kind_q  <= PM_NONE;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        ex_q    <= ex_d;
        sx_q    <= sx_d;
        sp_q    <= sp_d;
        kind_q  <= kind_d;
        out_v_q <= has_v;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && has_v) begin
      verdict_q <= v;
      dir_q     <= ev_i.dir;
      prog_q    <= p;
    end
  end

  assign out_valid_o         = out_v_q;
  assign verdict_o           = verdict_q;
  assign verdict_direction_o = dir_q;
  assign program_number_o    = prog_q;

endmodule

>>> src/onc_rpc_record_deframe_validate_core.sv
// top level: onc rpc record deframer with call/reply validation
// a byte that ends a record or fails a check shows its verdict after the parser step, the
// request queue and the result register, and later when that byte needs extra parser steps
// throughput: one byte per cycle while the request queue has room; a byte is held while
// parser steps that move phase without using the byte run
// reset clears parser, exchange and queue state; the header store is not cleared
module onc_rpc_record_deframe_validate_core import orpc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        from_responder_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        verdict_direction_o,
  output logic [31:0] program_number_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  ev_t  f_ev, b_ev;

  orpc_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .from_responder_i(from_responder_i),
    .ev_valid_o      (f_valid),
    .ev_o            (f_ev),
    .ev_ready_i      (f_ready)
  );

  orpc_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_i       (f_ev),
    .out_valid_o(b_valid),
    .out_ready_i(b_ready),
    .out_o      (b_ev)
  );

  orpc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ev_valid_i         (b_valid),
    .ev_ready_o         (b_ready),
    .ev_i               (b_ev),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .verdict_o          (verdict_o),
    .verdict_direction_o(verdict_direction_o),
    .program_number_o   (program_number_o)
  );

endmodule

>>> src/orpc_chk.sv
// port-level checks on the result channel, bound to the top level
module orpc_chk import orpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  verdict_o,
  input logic        verdict_direction_o,
  input logic [31:0] program_number_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
      $stable(verdict_direction_o) && $stable(program_number_o))
    else $error("result changed while stalled");

  a_prog_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && program_number_o != 32'd0 |-> verdict_o == V_OK)
    else $error("program number on a non-success verdict");

  a_nc_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == V_NC |-> !verdict_direction_o)
    else $error("not compatible verdict from responder side");

  a_ok_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == V_OK |-> verdict_direction_o)
    else $error("success verdict from initiator side");

endmodule

bind onc_rpc_record_deframe_validate_core orpc_chk u_chk (.*);
